[sv/proximity_led_brightness_map_macros.svh]
`ifndef PROXIMITY_LED_BRIGHTNESS_MAP_MACROS_SVH
`define PROXIMITY_LED_BRIGHTNESS_MAP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PLBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plbm check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define PLBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plbm check failed");

`endif

[sv/plbm_pkg.sv]
package plbm_pkg;

  typedef logic [15:0] word_t;

  localparam int LED_COUNT_DEF = 20;

  // configuration register indexes
  localparam logic [1:0] REG_REACH_LIMIT     = 2'd0;
  localparam logic [1:0] REG_FULL_BRIGHTNESS = 2'd1;
  localparam logic [1:0] REG_FULL_LOCATION   = 2'd2;

  localparam word_t REACH_LIMIT_RST     = 16'd16384;
  localparam word_t FULL_BRIGHTNESS_RST = 16'hFFFF;
  localparam word_t FULL_LOCATION_RST   = 16'hFFFF;
  localparam word_t LEVEL_MAX           = 16'hFFFF;

  // square root: 18 result bits, two per cycle
  localparam int ROOT_W    = 18;
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQRT_ITER = ROOT_W / 2;
  // divide: 16 quotient bits, two per cycle
  localparam int DIV_ITER  = 8;
  localparam int CNT_W     = 4;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  typedef struct packed {
    word_t acc;
    word_t q;
  } div_acc_t;

  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] pair);
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    sqrt_acc_t r;
    t = {a.rem, pair};
    trial = {{(REM_W - ROOT_W){1'b0}}, a.root, 2'b01};
    if (t >= trial) begin
      r.rem  = REM_W'(t - trial);
      r.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(t);
      r.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // restoring step, acc stays below d
  function automatic div_acc_t div_step(div_acc_t a, word_t d);
    logic [16:0] t;
    div_acc_t r;
    t = {a.acc, a.q[15]};
    if (t >= {1'b0, d}) begin
      r.acc = 16'(t - {1'b0, d});
      r.q   = {a.q[14:0], 1'b1};
    end else begin
      r.acc = t[15:0];
      r.q   = {a.q[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[sv/proximity_led_brightness_map.sv]
// proximity LED brightness map
// command channel: a request is taken when start is high and busy is low.
// kind 0 writes one LED coordinate entry (entry_index, entry_x, entry_y) in
// the same edge and leaves busy low; indexes at or above LED_COUNT are dropped.
// kind 1 is a hand position: busy rises and the block sends LED_COUNT
// results, one per strobe pulse, in LED order, last set on the final one.
// each result lasts one cycle and must be taken then; there is no stall.
// order: the red level takes one multiply and a check, then the divide unless
// the check saturates it; per LED the entry is read, the axis distances taken,
// squared and summed and the root found, and a lit LED is multiplied and
// divided; an LED dark by axis distance or with no hand, or out of reach after
// the root, skips to its output. the 2-bit-per-cycle square root and divider
// set the pace; the single port read of the coordinate memory serialises LEDs.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while busy is low.
// reset clears control state and loads the register defaults; the coordinate
// memory holds no defined content until each entry is written.
`include "proximity_led_brightness_map_macros.svh"

module proximity_led_brightness_map
  import plbm_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [4:0]  entry_index,
  input  logic [15:0] entry_x,
  input  logic [15:0] entry_y,
  input  logic [15:0] hand_x,
  input  logic [15:0] hand_y,
  input  logic [15:0] hand_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [4:0]  led_number,
  output logic [15:0] led_level,
  output logic [15:0] red_level,
  output logic        last
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RMUL, S_RCHK, S_RD, S_DIFF, S_SQX, S_SQY,
    S_SQRT, S_NEAR, S_LMUL, S_DIV, S_OUT
  } state_t;

  state_t state;

  word_t reach_limit;
  word_t full_brightness;
  word_t full_location;

  word_t             hx, hy, hz;
  logic              hand;
  logic [IDX_W-1:0]  idx;
  word_t             dx, dy;
  logic [SQ_W-1:0]   sq;
  sqrt_acc_t         sacc;
  word_t             near;
  div_acc_t          dacc;
  logic              div_red;
  logic [CNT_W-1:0]  cnt;
  word_t             level;
  word_t             red;

  logic        load_we;
  logic [31:0] rdata;
  word_t       lx, ly, dx_next, dy_next;
  word_t       mul_a, mul_b;
  logic [31:0] mul;
  word_t       divisor;
  div_acc_t    div_mid, div_next;
  sqrt_acc_t   sqrt_mid, sqrt_next;
  logic        idx_last;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_we   = start && !busy && !kind && (entry_index < LED_COUNT);

  plbm_ram #(
    .WIDTH (32),
    .DEPTH (LED_COUNT)
  ) u_coord_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (IDX_W'(entry_index)),
    .wdata ({entry_y, entry_x}),
    .re    (state == S_RD),
    .raddr (idx),
    .rdata (rdata)
  );

  assign lx      = rdata[15:0];
  assign ly      = rdata[31:16];
  assign dx_next = (hx >= lx) ? hx - lx : lx - hx;
  assign dy_next = (hy >= ly) ? hy - ly : ly - hy;

  // one shared 16x16 multiplier
  always_comb begin
    unique case (state)
      S_RMUL:  begin mul_a = hz;   mul_b = full_brightness; end
      S_SQX:   begin mul_a = dx;   mul_b = dx;              end
      S_SQY:   begin mul_a = dy;   mul_b = dy;              end
      S_LMUL:  begin mul_a = near; mul_b = full_brightness; end
      default: begin mul_a = dx;   mul_b = dx;              end
    endcase
  end
  assign mul = mul_a * mul_b;

  assign divisor   = div_red ? full_location : reach_limit;
  assign div_mid   = div_step(dacc, divisor);
  assign div_next  = div_step(div_mid, divisor);
  assign sqrt_mid  = sqrt_step(sacc, sq[SQ_W-1 -: 2]);
  assign sqrt_next = sqrt_step(sqrt_mid, sq[SQ_W-3 -: 2]);
  assign idx_last  = (idx == IDX_W'(LED_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      strobe          <= 1'b0;
      reach_limit     <= REACH_LIMIT_RST;
      full_brightness <= FULL_BRIGHTNESS_RST;
      full_location   <= FULL_LOCATION_RST;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_REACH_LIMIT:     reach_limit     <= cfg_data;
          REG_FULL_BRIGHTNESS: full_brightness <= cfg_data;
          REG_FULL_LOCATION:   full_location   <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start && kind) begin
            hx    <= hand_x;
            hy    <= hand_y;
            hz    <= hand_z;
            hand  <= (hand_x != 16'd0) && (hand_y != 16'd0);
            state <= S_RMUL;
          end
        end
        S_RMUL: begin
          dacc  <= {mul[31:16], mul[15:0]};
          state <= S_RCHK;
        end
        S_RCHK: begin
          // quotient would not fit in 16 bits, or no scale at all
          if (full_location == 16'd0 || dacc.acc >= full_location) begin
            red   <= LEVEL_MAX;
            idx   <= '0;
            state <= S_RD;
          end else begin
            div_red <= 1'b1;
            cnt     <= CNT_W'(DIV_ITER - 1);
            state   <= S_DIV;
          end
        end
        S_RD: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          dx <= dx_next;
          dy <= dy_next;
          if (hand && dx_next < reach_limit && dy_next < reach_limit) begin
            state <= S_SQX;
          end else begin
            level <= '0;
            state <= S_OUT;
          end
        end
        S_SQX: begin
          sq    <= SQ_W'(mul);
          state <= S_SQY;
        end
        S_SQY: begin
          sq    <= sq + SQ_W'(mul);
          sacc  <= '0;
          cnt   <= CNT_W'(SQRT_ITER - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          sacc <= sqrt_next;
          sq   <= {sq[SQ_W-5:0], 4'b0000};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_NEAR;
          end
        end
        S_NEAR: begin
          if (sacc.root < ROOT_W'(reach_limit)) begin
            near  <= reach_limit - sacc.root[15:0];
            state <= S_LMUL;
          end else begin
            level <= '0;
            state <= S_OUT;
          end
        end
        S_LMUL: begin
          // near <= limit keeps the high half below the divisor
          dacc    <= {mul[31:16], mul[15:0]};
          div_red <= 1'b0;
          cnt     <= CNT_W'(DIV_ITER - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          dacc <= div_next;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            if (div_red) begin
              red   <= div_next.q;
              idx   <= '0;
              state <= S_RD;
            end else begin
              level <= div_next.q;
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          strobe     <= 1'b1;
          led_number <= 5'(idx);
          led_level  <= level;
          red_level  <= red;
          last       <= idx_last;
          if (idx_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PLBM_ASSERT_NOW(a_last_is_final_led, strobe && last, led_number == 5'(LED_COUNT - 1))
  `PLBM_ASSERT_NOW(a_idle_after_last, strobe && last, !busy)
  `PLBM_ASSERT_NEXT(a_position_goes_busy, start && !busy && kind, busy && !strobe)
  `PLBM_ASSERT_NOW(a_dark_without_hand, strobe && !hand, led_level == 16'd0)

endmodule

[sv/plbm_ram.sv]
module plbm_ram
  import plbm_pkg::*;
#(
  parameter int WIDTH = 32,
  parameter int DEPTH = LED_COUNT_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
